>>> src/imt_pkg.sv
// Shared types and constants of the interval mask table.
`default_nettype none
package imt_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int VAL_W            = 32;
   localparam int MASK_W           = 16;
   localparam int ENTRY_W          = 2 * VAL_W + MASK_W;

   localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_ADD   = 2'd1,
      MODE_BUILD = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [VAL_W-1:0]   range_low;
      logic signed [VAL_W-1:0]   range_high;
      logic [MASK_W-1:0]         range_mask;
      logic signed [VAL_W-1:0]   obs_id;
      logic [7:0]                hint_index;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [MASK_W-1:0]   found_mask;
      logic                hit;
      logic [7:0]          found_index;
      logic [8:0]          segment_count;
   } rsp_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]   lo;
      logic signed [VAL_W-1:0]   hi;
      logic [MASK_W-1:0]         mask;
   } entry_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_res_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SORT_I,
      S_SORT_KEY,
      S_SORT_CMP,
      S_SORT_PUT,
      S_N_TOP,
      S_N_HEAD,
      S_N_SCAN,
      S_N_MIN,
      S_N_BRK,
      S_N_CUTCHK,
      S_N_CUT_TOP,
      S_N_CUT_CHK,
      S_N_CUT_EMP,
      S_N_CUT_CPY,
      S_N_EMIT,
      S_Q_TOP,
      S_Q_LO,
      S_Q_HI
   } state_type;

endpackage
`default_nettype wire

>>> src/interval_mask_table.sv
// Top level of the interval mask table: sequencer, stores and result register.
//
//   channel   ports                        transfer rule
//   request   start, busy, req_data        taken at an edge with start high, busy low
//   result    rsp_strobe, rsp_data         valid for exactly one cycle, always taken
//
// Clear and add finish in the accepting cycle; the result is registered and appears in
// the next cycle, and busy never rises. A query runs a binary search over the segment
// RAM, reading the middle segment and then checking its lower and upper bound per probe.
// A build is bound by the work RAM and its one read and one write port: an insertion sort
// by lower bound followed by a normalizing sweep over the sorted raw ranges.
// Reset is synchronous and clears the counts and the sequencer; the stores keep
// their contents and are only read below the counts. The receiver cannot stall.
`default_nettype none
module interval_mask_table #(
   parameter int CAPACITY = imt_pkg::CAPACITY_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire imt_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output imt_pkg::rsp_type      rsp_data
);
   import imt_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] raw_count_ff, raw_count_in;
   logic [CW-1:0] seg_count_ff, seg_count_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   entry_type key_ff, key_in, cur_ff, cur_in, last_ff, last_in;
   logic signed [CW:0] q_lo_ff, q_lo_in, q_hi_ff, q_hi_in;
   logic [AW-1:0] mid_ff, mid_in;

   // RAM ports
   logic              raw_we, raw_re, work_we, work_re, seg_we, seg_re;
   logic [AW-1:0]     raw_waddr, raw_raddr, work_waddr, work_raddr, seg_waddr, seg_raddr;
   entry_type         raw_wdata, work_wdata, seg_wdata;
   logic [ENTRY_W-1:0] raw_rbits, work_rbits, seg_rbits;
   entry_type         raw_rd, work_rd, seg_rd;

   // shared comparator
   logic signed [VAL_W-1:0] cmp_a, cmp_b;
   cmp_res_type             cmp_res;

   // index arithmetic
   logic [CW-1:0]        i_inc, i_dec, j_inc, j_dec, j_dec2;
   logic signed [CW+1:0] mid_sum;
   logic [AW-1:0]        mid_idx;
   logic signed [VAL_W-1:0] cur_hi_inc, rd_lo_dec;
   logic                 last_touch;

   assign raw_rd  = entry_type'(raw_rbits);
   assign work_rd = entry_type'(work_rbits);
   assign seg_rd  = entry_type'(seg_rbits);

   assign i_inc  = i_ff + CW'(1);
   assign i_dec  = i_ff - CW'(1);
   assign j_inc  = j_ff + CW'(1);
   assign j_dec  = j_ff - CW'(1);
   assign j_dec2 = j_ff - CW'(2);
   assign mid_sum = (CW+2)'(q_lo_ff) + (CW+2)'(q_hi_ff);
   assign mid_idx = mid_sum[AW:1];
   assign cur_hi_inc = cur_ff.hi + VAL_W'(1);
   assign rd_lo_dec  = work_rd.lo - VAL_W'(1);
   // last stored segment ends right before the one being emitted
   assign last_touch = (({last_ff.hi[VAL_W-1], last_ff.hi} + (VAL_W+1)'(1))
                        == {cur_ff.lo[VAL_W-1], cur_ff.lo});

   imt_cmp u_cmp (
      .a   (cmp_a),
      .b   (cmp_b),
      .res (cmp_res)
   );

   imt_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_raw_ram (
      .clock   (clock),
      .wr_en   (raw_we),
      .wr_addr (raw_waddr),
      .wr_data (raw_wdata),
      .rd_en   (raw_re),
      .rd_addr (raw_raddr),
      .rd_data (raw_rbits)
   );

   imt_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_work_ram (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (work_waddr),
      .wr_data (work_wdata),
      .rd_en   (work_re),
      .rd_addr (work_raddr),
      .rd_data (work_rbits)
   );

   imt_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_seg_ram (
      .clock   (clock),
      .wr_en   (seg_we),
      .wr_addr (seg_waddr),
      .wr_data (seg_wdata),
      .rd_en   (seg_re),
      .rd_addr (seg_raddr),
      .rd_data (seg_rbits)
   );

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         raw_count_ff <= '0;
         seg_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         raw_count_ff <= raw_count_in;
         seg_count_ff <= seg_count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      key_ff  <= key_in;
      cur_ff  <= cur_in;
      last_ff <= last_in;
      q_lo_ff <= q_lo_in;
      q_hi_ff <= q_hi_in;
      mid_ff  <= mid_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      raw_count_in = raw_count_ff;
      seg_count_in = seg_count_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      key_in  = key_ff;
      cur_in  = cur_ff;
      last_in = last_ff;
      q_lo_in = q_lo_ff;
      q_hi_in = q_hi_ff;
      mid_in  = mid_ff;
      raw_we = 1'b0;  raw_waddr = '0;  raw_wdata = '0;  raw_re = 1'b0;  raw_raddr = '0;
      work_we = 1'b0; work_waddr = '0; work_wdata = '0; work_re = 1'b0; work_raddr = '0;
      seg_we = 1'b0;  seg_waddr = '0;  seg_wdata = '0;  seg_re = 1'b0;  seg_raddr = '0;
      cmp_a = '0;
      cmp_b = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               rsp_in = '0;
               unique case (req_data.mode)
                  MODE_CLEAR: begin
                     raw_count_in = '0;
                     seg_count_in = '0;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_ADD: begin
                     rsp_in.segment_count = 9'(seg_count_ff);
                     rsp_valid_in = 1'b1;
                     if (raw_count_ff == CAP_C) begin
                        rsp_in.status = 1'b1;
                     end else begin
                        // swap reversed ends
                        cmp_a = req_data.range_high;
                        cmp_b = req_data.range_low;
                        raw_we    = 1'b1;
                        raw_waddr = raw_count_ff[AW-1:0];
                        raw_wdata.mask = req_data.range_mask;
                        if (cmp_res.lt) begin
                           raw_wdata.lo = req_data.range_high;
                           raw_wdata.hi = req_data.range_low;
                        end else begin
                           raw_wdata.lo = req_data.range_low;
                           raw_wdata.hi = req_data.range_high;
                        end
                        raw_count_in = raw_count_ff + CW'(1);
                     end
                  end
                  MODE_BUILD: begin
                     i_in     = '0;
                     state_in = S_SORT_I;
                  end
                  MODE_QUERY: begin
                     q_lo_in  = '0;
                     q_hi_in  = $signed({1'b0, seg_count_ff}) - (CW+1)'(1);
                     state_in = S_Q_TOP;
                  end
                  default: ;
               endcase
            end
         end

         // insertion sort of the raw ranges into the work RAM by lower bound
         S_SORT_I: begin
            if (i_ff == raw_count_ff) begin
               i_in         = '0;
               seg_count_in = '0;
               state_in     = S_N_TOP;
            end else begin
               raw_re    = 1'b1;
               raw_raddr = i_ff[AW-1:0];
               state_in  = S_SORT_KEY;
            end
         end
         S_SORT_KEY: begin
            key_in = raw_rd;
            j_in   = i_ff;
            if (i_ff == '0) begin
               state_in = S_SORT_PUT;
            end else begin
               work_re    = 1'b1;
               work_raddr = i_dec[AW-1:0];
               state_in   = S_SORT_CMP;
            end
         end
         S_SORT_CMP: begin
            cmp_a = key_ff.lo;
            cmp_b = work_rd.lo;
            if (cmp_res.lt) begin
               work_we    = 1'b1;
               work_waddr = j_ff[AW-1:0];
               work_wdata = work_rd;
               j_in       = j_dec;
               if (j_dec == '0) begin
                  state_in = S_SORT_PUT;
               end else begin
                  work_re    = 1'b1;
                  work_raddr = j_dec2[AW-1:0];
               end
            end else begin
               state_in = S_SORT_PUT;
            end
         end
         S_SORT_PUT: begin
            work_we    = 1'b1;
            work_waddr = j_ff[AW-1:0];
            work_wdata = key_ff;
            i_in       = i_inc;
            state_in   = S_SORT_I;
         end

         // normalizing sweep over the sorted work RAM
         S_N_TOP: begin
            if (i_ff >= raw_count_ff) begin
               rsp_in = '0;
               rsp_in.segment_count = 9'(seg_count_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               work_re    = 1'b1;
               work_raddr = i_ff[AW-1:0];
               state_in   = S_N_HEAD;
            end
         end
         S_N_HEAD: begin
            cur_in = work_rd;
            j_in   = i_inc;
            if (i_inc < raw_count_ff) begin
               work_re    = 1'b1;
               work_raddr = i_inc[AW-1:0];
               state_in   = S_N_SCAN;
            end else begin
               state_in = S_N_CUTCHK;
            end
         end
         S_N_SCAN: begin
            cmp_a = work_rd.lo;
            cmp_b = cur_ff.lo;
            if (cmp_res.eq) begin
               cur_in.mask = cur_ff.mask | work_rd.mask;
               state_in    = S_N_MIN;
            end else begin
               state_in = S_N_BRK;
            end
         end
         S_N_MIN: begin
            // same start: end at the smallest upper bound
            cmp_a = work_rd.hi;
            cmp_b = cur_ff.hi;
            if (cmp_res.lt) begin
               cur_in.hi = work_rd.hi;
            end
            j_in = j_inc;
            if (j_inc < raw_count_ff) begin
               work_re    = 1'b1;
               work_raddr = j_inc[AW-1:0];
               state_in   = S_N_SCAN;
            end else begin
               state_in = S_N_CUTCHK;
            end
         end
         S_N_BRK: begin
            // next start inside the segment: stop just before it
            cmp_a = cur_ff.hi;
            cmp_b = work_rd.lo;
            if (!cmp_res.lt) begin
               cur_in.hi = rd_lo_dec;
            end
            state_in = S_N_CUTCHK;
         end
         S_N_CUTCHK: begin
            if (cur_ff.hi == INT_MAX) begin
               i_in     = raw_count_ff;
               state_in = S_N_EMIT;
            end else begin
               j_in     = i_ff;
               state_in = S_N_CUT_TOP;
            end
         end
         S_N_CUT_TOP: begin
            if (j_ff >= raw_count_ff) begin
               state_in = S_N_EMIT;
            end else begin
               work_re    = 1'b1;
               work_raddr = j_ff[AW-1:0];
               state_in   = S_N_CUT_CHK;
            end
         end
         S_N_CUT_CHK: begin
            cmp_a = work_rd.lo;
            cmp_b = cur_ff.lo;
            if (cmp_res.eq) begin
               state_in = S_N_CUT_EMP;
            end else begin
               state_in = S_N_EMIT;
            end
         end
         S_N_CUT_EMP: begin
            cmp_a = cur_ff.hi;
            cmp_b = work_rd.hi;
            if (cmp_res.lt) begin
               // trim the covered part off the range
               work_we         = 1'b1;
               work_waddr      = j_ff[AW-1:0];
               work_wdata.lo   = cur_hi_inc;
               work_wdata.hi   = work_rd.hi;
               work_wdata.mask = work_rd.mask;
               j_in            = j_inc;
               state_in        = S_N_CUT_TOP;
            end else if (i_ff == j_ff) begin
               // range used up: drop it
               i_in     = i_inc;
               j_in     = j_inc;
               state_in = S_N_CUT_TOP;
            end else begin
               work_re    = 1'b1;
               work_raddr = i_ff[AW-1:0];
               state_in   = S_N_CUT_CPY;
            end
         end
         S_N_CUT_CPY: begin
            // move the entry at the head into the emptied slot
            work_we    = 1'b1;
            work_waddr = j_ff[AW-1:0];
            work_wdata = work_rd;
            i_in       = i_inc;
            j_in       = j_inc;
            state_in   = S_N_CUT_TOP;
         end
         S_N_EMIT: begin
            if (cur_ff.mask != '0) begin
               if (seg_count_ff != '0 && last_touch && last_ff.mask == cur_ff.mask) begin
                  seg_we         = 1'b1;
                  seg_waddr      = AW'(seg_count_ff - CW'(1));
                  seg_wdata      = last_ff;
                  seg_wdata.hi   = cur_ff.hi;
                  last_in.hi     = cur_ff.hi;
               end else if (seg_count_ff != CAP_C) begin
                  seg_we       = 1'b1;
                  seg_waddr    = seg_count_ff[AW-1:0];
                  seg_wdata    = cur_ff;
                  last_in      = cur_ff;
                  seg_count_in = seg_count_ff + CW'(1);
               end
            end
            state_in = S_N_TOP;
         end

         // binary search over the segment RAM
         S_Q_TOP: begin
            if (q_hi_ff < q_lo_ff) begin
               rsp_in = '0;
               rsp_in.found_index   = req_ff.hint_index;
               rsp_in.segment_count = 9'(seg_count_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               mid_in    = mid_idx;
               seg_re    = 1'b1;
               seg_raddr = mid_idx;
               state_in  = S_Q_LO;
            end
         end
         S_Q_LO: begin
            cmp_a = req_ff.obs_id;
            cmp_b = seg_rd.lo;
            if (cmp_res.lt) begin
               q_hi_in  = (CW+1)'($signed({1'b0, mid_ff})) - (CW+1)'(1);
               state_in = S_Q_TOP;
            end else begin
               state_in = S_Q_HI;
            end
         end
         S_Q_HI: begin
            cmp_a = seg_rd.hi;
            cmp_b = req_ff.obs_id;
            if (cmp_res.lt) begin
               q_lo_in  = (CW+1)'($signed({1'b0, mid_ff})) + (CW+1)'(1);
               state_in = S_Q_TOP;
            end else begin
               rsp_in = '0;
               rsp_in.found_mask    = seg_rd.mask;
               rsp_in.hit           = 1'b1;
               rsp_in.found_index   = 8'(mid_ff);
               rsp_in.segment_count = 9'(seg_count_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> src/imt_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module imt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> src/imt_cmp.sv
// Shared signed comparator: one 33-bit subtract gives less-than and equal.
`default_nettype none
module imt_cmp (
   input  wire logic signed [imt_pkg::VAL_W-1:0] a,
   input  wire logic signed [imt_pkg::VAL_W-1:0] b,
   output imt_pkg::cmp_res_type                  res
);
   import imt_pkg::*;

   logic signed [VAL_W:0] diff;

   assign diff   = {a[VAL_W-1], a} - {b[VAL_W-1], b};
   assign res.lt = diff[VAL_W];
   assign res.eq = (diff == '0);

endmodule
`default_nettype wire
